/* src/dfr_pkg.sv */
package dfr_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [2:0]  SIZE_REGS   = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_TYPE_LIMIT  = 3'd0;
    localparam logic [2:0] REG_SIZE_ONE    = 3'd1;
    localparam logic [2:0] REG_SIZE_TWO    = 3'd2;
    localparam logic [2:0] REG_SIZE_THREE  = 3'd3;
    localparam logic [2:0] REG_SIZE_FOUR   = 3'd4;

    // Command into the serial CRC unit.
    typedef struct packed {
        logic       init;
        logic       load;
        logic [7:0] data;
    } crc_cmd_t;

endpackage

/* src/dfr_crc_serial.sv */
module dfr_crc_serial
    import dfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  crc_cmd_t    cmd,
    output logic        busy,
    output logic [31:0] crc
);

    logic [31:0] crc_reg, crc_next;
    logic [7:0]  data_reg, data_next;
    logic [2:0]  bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        fb;

    // One message bit per cycle, most significant bit first.
    always_comb begin
        crc_next  = crc_reg;
        data_next = data_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        fb        = crc_reg[31] ^ data_reg[7];
        if (cmd.load) begin
            if (cmd.init) begin
                crc_next = CRC_INIT;
            end
            data_next = cmd.data;
            bit_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            crc_next  = {crc_reg[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'd0);
            data_next = {data_reg[6:0], 1'b0};
            bit_next  = bit_reg + 3'd1;
            if (bit_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= CRC_INIT;
            bit_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            bit_reg  <= bit_next;
            busy_reg <= busy_next;
        end
        data_reg <= data_next;
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

/* src/dfr_payload_mem.sv */
module dfr_payload_mem #(
    parameter int DEPTH = 17,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sync_framed_packet_deframer_crc32.sv */
// Channel     Direction  Handshake          Payload
// s_ (input)  in         s_valid / s_ready  s_rx_byte
// m_ (result) out        m_valid / m_ready  m_kind, m_payload_byte, m_byte_index, m_last
// config      in/out     APB (psel/penable) paddr, pwdata, prdata
//
// Sync bytes and check bytes are taken whenever offered. The bit-serial CRC unit
// works through each byte bit by bit, so a valid type byte and its three zero
// bytes hold off the first payload byte, and each payload or pad byte waits for
// it. A passing packet is read out of the payload memory byte by byte, through
// ST_EMIT_RD and ST_EMIT_LD; a stall on m_ready holds it up. Reset is synchronous,
// active low on aresetn. A result held in the output register does not stop intake.
module sync_framed_packet_deframer_crc32
    import dfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 17,
    parameter int TYPE_SLOTS  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [4:0]  m_byte_index,
    output logic        m_last,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Counter width holds MAX_PAYLOAD itself, and at least two bits so
    // that the word alignment of the payload can be read from it.
    localparam int CW_RAW = $clog2(MAX_PAYLOAD + 1);
    localparam int CNT_W  = (CW_RAW < 2) ? 2 : CW_RAW;
    localparam int AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [3:0] ST_HUNT0   = 4'd0;
    localparam logic [3:0] ST_HUNT1   = 4'd1;
    localparam logic [3:0] ST_TYPE    = 4'd2;
    localparam logic [3:0] ST_TPAD    = 4'd3;
    localparam logic [3:0] ST_PAYLOAD = 4'd4;
    localparam logic [3:0] ST_PPAD    = 4'd5;
    localparam logic [3:0] ST_CHECK   = 4'd6;
    localparam logic [3:0] ST_EMIT_RD = 4'd7;
    localparam logic [3:0] ST_EMIT_LD = 4'd8;

    // Configuration registers.
    logic [2:0] type_limit_reg;
    logic [4:0] size_reg [4];

    logic [3:0]       state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic [CNT_W-1:0] size_exp_reg, size_exp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       pad_reg, pad_next;
    logic [31:0]      recv_reg, recv_next;

    logic [CNT_W-1:0] cnt_plus;
    logic [4:0]       size_sel;
    logic [6:0]       size_clamp;
    logic             type_ok;
    logic             s_fire;

    crc_cmd_t    crc_cmd;
    logic        crc_busy;
    logic [31:0] crc_value;

    logic        mem_wr;
    logic        mem_rd;
    logic [7:0]  mem_rdata;

    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [7:0]  m_payload_reg;
    logic [4:0]  m_index_reg;
    logic        m_last_reg;
    logic        emit_last;

    // APB: always ready; writes land on the access phase.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_limit_reg <= 3'd5;
            for (int i = 0; i < 4; i++) begin
                size_reg[i] <= 5'd17;
            end
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_TYPE_LIMIT: type_limit_reg <= pwdata[2:0];
                REG_SIZE_ONE:   size_reg[0]    <= pwdata[4:0];
                REG_SIZE_TWO:   size_reg[1]    <= pwdata[4:0];
                REG_SIZE_THREE: size_reg[2]    <= pwdata[4:0];
                REG_SIZE_FOUR:  size_reg[3]    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TYPE_LIMIT: prdata = {29'd0, type_limit_reg};
            REG_SIZE_ONE:   prdata = {27'd0, size_reg[0]};
            REG_SIZE_TWO:   prdata = {27'd0, size_reg[1]};
            REG_SIZE_THREE: prdata = {27'd0, size_reg[2]};
            REG_SIZE_FOUR:  prdata = {27'd0, size_reg[3]};
            default:        prdata = 32'd0;
        endcase
    end

    // Intake is open in every framing phase except while the CRC unit is
    // still chewing on the previous payload byte. Pad phases and readout
    // take no requests.
    always_comb begin
        unique case (state_reg)
            ST_HUNT0, ST_HUNT1, ST_TYPE, ST_CHECK: s_ready = 1'b1;
            ST_PAYLOAD:                            s_ready = !crc_busy;
            default:                               s_ready = 1'b0;
        endcase
    end

    assign s_fire = s_valid && s_ready;

    // A type is valid when it is nonzero, below the programmed limit and
    // inside both the slot count and the four size registers.
    assign type_ok = (s_rx_byte != 8'd0)
                  && (s_rx_byte < {5'd0, type_limit_reg})
                  && (s_rx_byte <= 8'(TYPE_SLOTS))
                  && (s_rx_byte <= {5'd0, SIZE_REGS});

    always_comb begin
        unique case (s_rx_byte[1:0])
            2'd1:    size_sel = size_reg[0];
            2'd2:    size_sel = size_reg[1];
            2'd3:    size_sel = size_reg[2];
            default: size_sel = size_reg[3];
        endcase
        // A size of zero counts as one; anything above the store is capped.
        if (size_sel == 5'd0) begin
            size_clamp = 7'd1;
        end else if ({2'd0, size_sel} > 7'(MAX_PAYLOAD)) begin
            size_clamp = 7'(MAX_PAYLOAD);
        end else begin
            size_clamp = {2'd0, size_sel};
        end
    end

    assign cnt_plus  = cnt_reg + CNT_W'(1);
    assign emit_last = (cnt_plus == size_exp_reg);

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        size_exp_next = size_exp_reg;
        cnt_next      = cnt_reg;
        pad_next      = pad_reg;
        recv_next     = recv_reg;
        crc_cmd       = '0;
        mem_wr        = 1'b0;
        mem_rd        = 1'b0;
        unique case (state_reg)
            ST_HUNT0: begin
                if (s_fire && s_rx_byte == SYNC_FIRST) begin
                    state_next = ST_HUNT1;
                end
            end
            ST_HUNT1: begin
                if (s_fire) begin
                    if (s_rx_byte == SYNC_SECOND) begin
                        state_next = ST_TYPE;
                    end else if (s_rx_byte != SYNC_FIRST) begin
                        state_next = ST_HUNT0;
                    end
                end
            end
            ST_TYPE: begin
                if (s_fire) begin
                    if (type_ok) begin
                        kind_next     = s_rx_byte[2:0];
                        size_exp_next = CNT_W'(size_clamp);
                        cnt_next      = '0;
                        pad_next      = 2'd3;
                        crc_cmd.init  = 1'b1;
                        crc_cmd.load  = 1'b1;
                        crc_cmd.data  = s_rx_byte;
                        state_next    = ST_TPAD;
                    end else begin
                        state_next = ST_HUNT0;
                    end
                end
            end
            ST_TPAD, ST_PPAD: begin
                // Feed zero bytes until the pad count runs out.
                if (!crc_busy) begin
                    if (pad_reg != 2'd0) begin
                        crc_cmd.load = 1'b1;
                        crc_cmd.data = 8'd0;
                        pad_next     = pad_reg - 2'd1;
                    end else if (state_reg == ST_TPAD) begin
                        state_next = ST_PAYLOAD;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (s_fire) begin
                    mem_wr       = 1'b1;
                    crc_cmd.load = 1'b1;
                    crc_cmd.data = s_rx_byte;
                    cnt_next     = cnt_plus;
                    if (cnt_plus >= size_exp_reg) begin
                        // Pad the payload to a whole number of words.
                        pad_next   = 2'(3'd4 - {1'b0, cnt_plus[1:0]});
                        cnt_next   = '0;
                        recv_next  = 32'd0;
                        state_next = ST_PPAD;
                    end
                end
            end
            ST_CHECK: begin
                if (s_fire) begin
                    recv_next = {s_rx_byte, recv_reg[31:8]};
                    cnt_next  = cnt_plus;
                    if (cnt_reg[1:0] == 2'd3) begin
                        cnt_next = '0;
                        if (recv_next == crc_value) begin
                            state_next = ST_EMIT_RD;
                        end else begin
                            state_next = ST_HUNT0;
                        end
                    end
                end
            end
            ST_EMIT_RD: begin
                // Wait for the output register to drain before reading on.
                if (!m_valid_reg) begin
                    mem_rd     = 1'b1;
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                if (emit_last) begin
                    cnt_next   = '0;
                    state_next = ST_HUNT0;
                end else begin
                    cnt_next   = cnt_plus;
                    state_next = ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_HUNT0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HUNT0;
            kind_reg     <= 3'd0;
            size_exp_reg <= '0;
            cnt_reg      <= '0;
            pad_reg      <= 2'd0;
            recv_reg     <= 32'd0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            size_exp_reg <= size_exp_next;
            cnt_reg      <= cnt_next;
            pad_reg      <= pad_next;
            recv_reg     <= recv_next;
        end
    end

    // The output register is loaded in the cycle after the memory read and
    // holds its result until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT_LD) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_EMIT_LD) begin
            m_kind_reg    <= kind_reg;
            m_payload_reg <= mem_rdata;
            m_index_reg   <= 5'(cnt_reg);
            m_last_reg    <= emit_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_payload_byte = m_payload_reg;
    assign m_byte_index   = m_index_reg;
    assign m_last         = m_last_reg;

    dfr_crc_serial u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (crc_cmd),
        .busy    (crc_busy),
        .crc     (crc_value)
    );

    dfr_payload_mem #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (s_rx_byte),
        .rd_en   (mem_rd),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

endmodule
